/* rtl/ffha_pkg.sv */
// ffha_pkg: shared types and constants for the first-fit heap allocator
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
package ffha_pkg;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_NO_MEMORY = 3'd1;
    localparam logic [2:0] ST_RELEASED  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_NULL      = 3'd4;

    typedef struct packed {
        logic        operation;
        logic [23:0] request_bytes;
        logic [17:0] release_address;
    } t_in_word;

    typedef struct packed {
        logic [17:0] payload_address;
        logic [2:0]  status;
    } t_out_word;

    // datapath commands, one per controller step
    typedef enum logic [3:0] {
        CMD_NONE      = 4'd0,
        CMD_LOAD      = 4'd1,  // latch request, point walk at head
        CMD_READ      = 4'd2,  // issue header read of walk pointer
        CMD_STEP      = 4'd3,  // examine read header, advance
        CMD_GROW      = 4'd4,  // claim new region at break
        CMD_GROW_TAIL = 4'd5,  // merge or link grown region at tail
        CMD_SPLIT     = 4'd6,  // split / mark used the found chunk
        CMD_RD_NEXT   = 4'd7,  // free released chunk, read its successor
        CMD_MERGE_FWD = 4'd8,
        CMD_RD_PREV   = 4'd9,
        CMD_MERGE_BWD = 4'd10
    } t_cmd;

    typedef struct packed {
        logic hit;       // current header satisfies the search
        logic at_end;    // current header has no successor
        logic grow_fail; // growth would pass arena end
        logic no_list;   // list not yet present
        logic bad_addr;  // release address malformed
        logic null_addr; // release address zero
        logic limit;     // walk bound reached
    } t_status;

endpackage

/* rtl/first_fit_heap_allocator.sv */
// first_fit_heap_allocator: top level, controller plus datapath with output register
// depends on ffha_pkg, ffha_ctrl, ffha_datapath
//
// usage: one request word on i_in_* (allocate or release); one result word on o_out_*.
// both channels are valid/ready; a word moves when valid and ready are high at an edge.
// the chunk list is walked by alternating a header read and a step that examines it;
// an allocate that finds a chunk then splits it, one that reaches the tail grows the
// break, merges or links the new region at the tail and splits it (the very first
// region is split directly), and one that cannot grow reports no memory.
// a release that finds its chunk reads and merges the successor, then the predecessor;
// an unknown pointer is reported when the walk ends, a null or malformed address before any read.
// one request is in flight at a time; a finished result sits in the output register
// and the next word is accepted only once that register is free or being drained.
// synchronous active-low reset clears break and list state; chunk headers are
// only read after being written, so they have no reset.
// if the receiver stalls, the result holds on o_out_word and input stays blocked.
`timescale 1ns / 1ps
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int ARENA_BYTES = 262144
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);
    // granule index width
    localparam int GW = $clog2(ARENA_BYTES / 16);

    t_cmd       w_cmd;
    t_status    w_stat;
    logic       w_done, w_addr_valid;
    logic [2:0] w_status;
    logic [GW:0] w_res_g;
    logic       r_out_valid;
    t_out_word  r_out_word;

    ffha_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_op(i_in_word.operation), .o_in_ready,
        .i_stat(w_stat), .o_cmd(w_cmd), .o_done(w_done), .o_status(w_status),
        .o_addr_valid(w_addr_valid),
        .i_out_free(!r_out_valid || i_out_ready)
    );

    ffha_datapath #(.GW(GW)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_word(i_in_word),
        .o_stat(w_stat), .o_result_g(w_res_g)
    );

    // payload address = chunk start * 16 + 32, kept to 18 bits
    logic [GW+5:0] w_addr;
    assign w_addr = {1'b0, w_res_g, 4'd0} + (GW+6)'(32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
        if (w_done) begin
            r_out_word.status <= w_status;
            r_out_word.payload_address <= w_addr_valid ? w_addr[17:0] : 18'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && i_in_valid |=> !o_in_ready) else $error("second word taken");
endmodule

/* rtl/ffha_datapath.sv */
// ffha_datapath: chunk header memories, break register and walk pointers
// depends on ffha_pkg
`timescale 1ns / 1ps
module ffha_datapath
    import ffha_pkg::*;
#(
    parameter int GW = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_word  i_word,
    output t_status   o_stat,
    output logic [GW:0] o_result_g
);
    localparam int          DEPTH  = 1 << GW;
    localparam logic [GW:0] GRANS  = (GW+1)'(DEPTH);

    // entry: size (GW+1 bits), link (GW bits), used
    logic [GW:0]   m_size [DEPTH];
    logic [GW-1:0] m_link [DEPTH];
    logic          m_used [DEPTH];

    logic [GW:0]   r_rd_size;
    logic [GW-1:0] r_rd_link;
    logic          r_rd_used;

    logic          r_op;
    logic [25:0]   r_need;     // granules needed, wide enough for huge requests
    logic [GW-1:0] r_target;
    logic          r_bad, r_null;
    logic [GW-1:0] r_ptr, r_prev, r_cur;
    logic          r_has_prev;
    logic [GW:0]   r_brk;
    logic          r_present;
    logic [GW:0]   r_cnt;
    logic [GW:0]   r_cur_size;
    logic [GW-1:0] r_cur_link;
    logic [GW:0]   r_amt;

    logic [20:0] n_need_c;
    logic [25:0] n_amt_w;
    logic [26:0] n_grow_end;
    logic        n_fits;

    always_comb begin
        n_need_c = 21'(({1'b0, (i_word.request_bytes == 24'd0 ? 24'd1
                       : i_word.request_bytes)} + 25'd15) >> 4);
        // grow amount in granules: max(need,4096) rounded to 256
        n_amt_w    = (r_need < 26'd4096) ? 26'd4096 : ((r_need + 26'd255) & ~26'd255);
        n_grow_end = 27'(r_brk) + 27'(n_amt_w);
        n_fits     = n_grow_end <= 27'(DEPTH);
    end

    always_comb begin
        o_stat.at_end    = (r_rd_link == '0);
        o_stat.hit       = r_op ? (r_ptr == r_target)
                         : (!r_rd_used && 26'(r_rd_size) >= r_need);
        o_stat.grow_fail = !n_fits;
        o_stat.no_list   = !r_present;
        o_stat.bad_addr  = r_bad;
        o_stat.null_addr = r_null;
        o_stat.limit     = (r_cnt == GRANS);
    end

    assign o_result_g = {1'b0, r_cur};

    logic [25:0] n_split_end;
    assign n_split_end = 26'(r_cur) + r_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk     <= '0;
            r_present <= 1'b0;
        end else begin
            unique case (i_cmd)
                CMD_LOAD: begin
                    r_op   <= i_word.operation;
                    r_need <= 26'(n_need_c) + 26'd2;
                    r_target <= GW'((i_word.release_address - 18'd32) >> 4);
                    r_null <= (i_word.release_address == 18'd0);
                    r_bad  <= (i_word.release_address < 18'd32)
                           || (i_word.release_address[3:0] != 4'd0)
                           || ({6'd0, i_word.release_address - 18'd32} >> 4 >= 24'(DEPTH));
                    r_ptr  <= '0;
                    r_has_prev <= 1'b0;
                    r_cnt  <= '0;
                end
                CMD_READ: begin
                    r_rd_size <= m_size[r_ptr];
                    r_rd_link <= m_link[r_ptr];
                    r_rd_used <= m_used[r_ptr];
                    r_cur      <= r_ptr;
                end
                CMD_STEP: begin
                    r_cur_size <= r_rd_size;
                    r_cur_link <= r_rd_link;
                    if (!(o_stat.hit || o_stat.at_end)) begin
                        r_prev     <= r_ptr;
                        r_has_prev <= 1'b1;
                        r_ptr      <= r_rd_link;
                        r_cnt      <= r_cnt + 1'b1;
                    end
                end
                CMD_GROW: begin
                    r_amt <= (GW+1)'(n_amt_w);
                    r_brk <= (GW+1)'(n_grow_end);
                    m_size[r_brk[GW-1:0]] <= (GW+1)'(n_amt_w);
                    m_link[r_brk[GW-1:0]] <= '0;
                    m_used[r_brk[GW-1:0]] <= 1'b0;
                    r_cur_size <= (GW+1)'(n_amt_w);
                    r_cur_link <= '0;
                    if (!r_present) begin
                        r_present <= 1'b1;
                        r_cur     <= r_brk[GW-1:0];
                        r_rd_used <= 1'b1; // no tail merge
                    end
                    r_ptr <= r_brk[GW-1:0];
                end
                CMD_GROW_TAIL: begin
                    // r_cur/r_rd_* hold tail header, r_ptr new chunk
                    if (!r_rd_used && ({1'b0, r_cur} + r_rd_size) == {1'b0, r_ptr}) begin
                        m_size[r_cur] <= r_rd_size + r_amt;
                        r_cur_size    <= r_rd_size + r_amt;
                        r_cur_link    <= r_rd_link;
                    end else begin
                        m_link[r_cur] <= r_ptr;
                        r_cur <= r_ptr;
                    end
                end
                CMD_SPLIT: begin
                    if (26'(r_cur_size) >= r_need + 26'd3
                        && n_split_end < 26'(DEPTH)) begin
                        m_size[n_split_end[GW-1:0]] <= r_cur_size - (GW+1)'(r_need);
                        m_used[n_split_end[GW-1:0]] <= 1'b0;
                        m_link[n_split_end[GW-1:0]] <= r_cur_link;
                        m_size[r_cur] <= (GW+1)'(r_need);
                        m_link[r_cur] <= n_split_end[GW-1:0];
                    end
                    m_used[r_cur] <= 1'b1;
                end
                CMD_RD_NEXT: begin
                    m_used[r_cur] <= 1'b0;
                    r_rd_size <= m_size[r_cur_link];
                    r_rd_link <= m_link[r_cur_link];
                    r_rd_used <= m_used[r_cur_link];
                end
                CMD_MERGE_FWD: begin
                    if (r_cur_link != '0 && !r_rd_used
                        && ({1'b0, r_cur} + r_cur_size) == {1'b0, r_cur_link}) begin
                        m_size[r_cur] <= r_cur_size + r_rd_size;
                        m_link[r_cur] <= r_rd_link;
                        r_cur_size <= r_cur_size + r_rd_size;
                        r_cur_link <= r_rd_link;
                    end
                end
                CMD_RD_PREV: begin
                    r_rd_size <= m_size[r_prev];
                    r_rd_used <= m_used[r_prev];
                end
                CMD_MERGE_BWD: begin
                    if (r_has_prev && !r_rd_used
                        && ({1'b0, r_prev} + r_rd_size) == {1'b0, r_cur}) begin
                        m_size[r_prev] <= r_rd_size + r_cur_size;
                        m_link[r_prev] <= r_cur_link;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/ffha_ctrl.sv */
// ffha_ctrl: sequencer for list walks, growth, split and merge
// depends on ffha_pkg
`timescale 1ns / 1ps
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    output logic    o_in_ready,
    input  t_status i_stat,
    output t_cmd    o_cmd,
    output logic    o_done,
    output logic [2:0] o_status,
    output logic    o_addr_valid,
    input  logic    i_out_free
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_STEP  = 10'b0000000100,
        S_GROW  = 10'b0000001000,
        S_TAIL  = 10'b0000010000,
        S_SPLIT = 10'b0000100000,
        S_RDNX  = 10'b0001000000,
        S_MFWD  = 10'b0010000000,
        S_RDPV  = 10'b0100000000,
        S_MBWD  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_op;

    assign o_in_ready = (r_state == S_IDLE) && i_out_free;

    always_comb begin
        n_state = r_state;
        o_cmd = CMD_NONE;
        o_done = 1'b0;
        o_status = ST_ALLOCATED;
        o_addr_valid = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid && o_in_ready) begin
                o_cmd = CMD_LOAD;
                n_state = S_READ;
            end
            S_READ: begin
                if (r_op && i_stat.null_addr) begin
                    o_done = 1'b1; o_status = ST_NULL; n_state = S_IDLE;
                end else if (r_op && (i_stat.bad_addr || i_stat.no_list)) begin
                    o_done = 1'b1; o_status = ST_UNKNOWN; n_state = S_IDLE;
                end else if (!r_op && i_stat.no_list) begin
                    n_state = S_GROW;
                end else begin
                    o_cmd = CMD_READ; n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd = CMD_STEP;
                if (i_stat.hit) begin
                    n_state = r_op ? S_RDNX : S_SPLIT;
                end else if (i_stat.at_end || i_stat.limit) begin
                    if (r_op) begin
                        o_done = 1'b1; o_status = ST_UNKNOWN; n_state = S_IDLE;
                    end else n_state = S_GROW;
                end else n_state = S_READ;
            end
            S_GROW: begin
                if (i_stat.grow_fail) begin
                    o_done = 1'b1; o_status = ST_NO_MEMORY; n_state = S_IDLE;
                end else begin
                    // the walk stopped at the tail, so its header is still held
                    o_cmd = CMD_GROW;
                    n_state = i_stat.no_list ? S_SPLIT : S_TAIL;
                end
            end
            S_TAIL:  begin o_cmd = CMD_GROW_TAIL; n_state = S_SPLIT; end
            S_SPLIT: begin
                o_cmd = CMD_SPLIT; o_done = 1'b1; o_status = ST_ALLOCATED;
                o_addr_valid = 1'b1; n_state = S_IDLE;
            end
            S_RDNX:  begin o_cmd = CMD_RD_NEXT; n_state = S_MFWD; end
            S_MFWD:  begin o_cmd = CMD_MERGE_FWD; n_state = S_RDPV; end
            S_RDPV:  begin o_cmd = CMD_RD_PREV; n_state = S_MBWD; end
            S_MBWD:  begin
                o_cmd = CMD_MERGE_BWD; o_done = 1'b1; o_status = ST_RELEASED;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd == CMD_LOAD) begin
                r_op <= i_in_op;
            end
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == S_IDLE) else $error("done without return to idle");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd == CMD_LOAD |-> i_out_free) else $error("load while output busy");
endmodule
